>>> sv/lzss_pkg.sv
package lzss_pkg;

	localparam int HistBytesDef = 65536;
	localparam int Slots = 32;
	localparam int MaxMatch = 8;
	localparam int Contexts = 256;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} lzss_in_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       run_last;
		logic       stream_end;
		logic       overflowed;
	} lzss_out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_CNT_RD,
		ST_SLOT_RD,
		ST_SLOT_WAIT,
		ST_CMP_RD,
		ST_CMP_WAIT,
		ST_CMP,
		ST_TOKEN,
		ST_CTX_RD,
		ST_CTX_WAIT,
		ST_EMIT,
		ST_FLUSH
	} lzss_state_t;

endpackage

>>> sv/lzss_context_slot_compressor.sv
// an input transfer that completes no token is followed by the check and flush states
// before ready rises again; a token reads its context counter, then per checked slot the
// slot entry and each compared byte (single shared history read port), then emits bytes
// throughput: one input byte at a time; not ready while tokens are encoded or emitted
// reset: arst_n clears control state, then a clear pass over all 256 context counters runs
// before the first byte is taken; the same pass follows every end mark; memories not reset
module lzss_context_slot_compressor
	import lzss_pkg::*;
#(
	parameter int HistoryBytes = HistBytesDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lzss_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output lzss_out_t out_data
);
	localparam int AW = $clog2(HistoryBytes);
	localparam int CW = AW + 1;

	lzss_state_t state_q, state_d;

	// stream state
	logic [CW-1:0] rcvd_q;
	logic [CW-1:0] pos_q;
	logic [7:0]    ctx_q;
	logic [15:0]   acc_q;
	// holds up to 16 bits right after a token
	logic [4:0]    nbits_q;
	logic          ovf_q;
	logic          end_q;

	// per-token search state
	logic [5:0]    cnt_q;
	logic [5:0]    slot_q;
	logic [3:0]    len_q;
	logic [3:0]    limit_q;
	logic [CW-1:0] src_q;
	logic [7:0]    cur_q;
	logic [3:0]    best_len_q;
	logic [4:0]    best_slot_q;
	logic [8:0]    clr_q;

	// memories
	logic          h_we;
	logic [AW-1:0] h_waddr, h_raddr;
	logic [7:0]    h_rdata;
	logic          s_we;
	logic [12:0]   s_waddr, s_raddr;
	logic [CW-1:0] s_wdata, s_rdata;
	logic          c_we;
	logic [7:0]    c_waddr;
	logic [5:0]    c_wdata, c_rdata;

	lzss_ram #(.Width(8), .Depth(HistoryBytes)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(in_data.data_byte),
		.raddr(h_raddr), .rdata(h_rdata)
	);
	lzss_ram #(.Width(CW), .Depth(Contexts * Slots)) u_slot (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	lzss_ram #(.Width(6), .Depth(Contexts)) u_cnt (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(ctx_q), .rdata(c_rdata)
	);

	logic [CW-1:0] avail;
	logic          xfer_in, xfer_out;
	logic          need_token;
	logic [CW-1:0] a_addr, b_addr;
	logic          a_ok, b_ok;
	logic [8:0]    word;
	logic [3:0]    tok_len;
	logic [CW-1:0] last_pos;
	logic [5:0]    check;
	logic          slot_done;
	logic          emit_last;
	logic [7:0]    a_byte_q;
	logic          miss_q;

	assign avail      = rcvd_q - pos_q;
	assign xfer_in    = in_valid && in_ready;
	assign xfer_out   = out_valid && out_ready;
	assign need_token = (avail >= CW'(MaxMatch)) || (end_q && (rcvd_q > pos_q));
	assign check      = cnt_q[5] ? 6'd32 : cnt_q;
	assign a_addr     = src_q + CW'(len_q);
	assign b_addr     = pos_q + CW'(len_q);
	assign a_ok       = a_addr < CW'(HistoryBytes);
	assign b_ok       = b_addr < CW'(HistoryBytes);
	assign slot_done  = (len_q >= limit_q) || miss_q || !a_ok || !b_ok;
	assign tok_len    = (best_len_q == 4'd0) ? 4'd1 : best_len_q;
	// position already advanced past the token when the context byte is read
	assign last_pos   = pos_q - CW'(1);
	// literal byte comes from cur_q, read at the token start
	assign word = (best_len_q != 4'd0) ? {1'b0, best_slot_q, 3'(best_len_q - 4'd1)}
		: {1'b1, cur_q};
	// no byte left in the accumulator, no token and no tail byte after this one
	assign emit_last  = (nbits_q - 5'd8 < 5'd8) && !need_token
		&& !(end_q && nbits_q != 5'd8);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:     if (clr_q == 9'd255) state_d = ST_IDLE;
			ST_IDLE:      if (xfer_in) state_d = ST_CHECK;
			ST_CHECK:     state_d = need_token ? ST_CNT_RD : ST_FLUSH;
			ST_CNT_RD:    state_d = ST_SLOT_RD;
			ST_SLOT_RD:   state_d = (slot_q == check) ? ST_TOKEN : ST_SLOT_WAIT;
			ST_SLOT_WAIT: state_d = ST_CMP_RD;
			ST_CMP_RD: begin
				if (slot_done) state_d = ST_SLOT_RD;
				else state_d = ST_CMP_WAIT;
			end
			ST_CMP_WAIT:  state_d = ST_CMP;
			ST_CMP:       state_d = ST_CMP_RD;
			ST_TOKEN:     state_d = ST_CTX_RD;
			ST_CTX_RD:    state_d = ST_CTX_WAIT;
			ST_CTX_WAIT:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (nbits_q < 5'd8) state_d = ST_CHECK;
				else if (xfer_out) state_d = (nbits_q - 5'd8 >= 5'd8) ? ST_EMIT : ST_CHECK;
			end
			ST_FLUSH: begin
				// without an end mark return to idle; at end of stream, clear the context counters first
				if (!end_q) state_d = ST_IDLE;
				else if (nbits_q == 5'd0 || xfer_out) state_d = ST_CLEAR;
			end
			default:      state_d = ST_CLEAR;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		h_we     = xfer_in && (rcvd_q < CW'(HistoryBytes));
		h_waddr  = rcvd_q[AW-1:0];
		h_raddr  = pos_q[AW-1:0];
		if (state_q == ST_CMP_RD) h_raddr = a_addr[AW-1:0];
		if (state_q == ST_CMP_WAIT) h_raddr = b_addr[AW-1:0];
		if (state_q == ST_CTX_RD) h_raddr = last_pos[AW-1:0];
		s_raddr  = {ctx_q, slot_q[4:0]};
		s_we     = (state_q == ST_TOKEN);
		s_waddr  = {ctx_q, cnt_q[4:0]};
		s_wdata  = pos_q;
		c_we     = (state_q == ST_CLEAR) || (state_q == ST_TOKEN);
		c_waddr  = (state_q == ST_CLEAR) ? clr_q[7:0] : ctx_q;
		c_wdata  = 6'd0;
		if (state_q == ST_TOKEN) c_wdata = cnt_q[5] ? {1'b1, cnt_q[4:0] + 5'd1} : cnt_q + 6'd1;
		out_valid = ((state_q == ST_EMIT) && nbits_q >= 5'd8)
			|| ((state_q == ST_FLUSH) && end_q && nbits_q != 5'd0);
		out_data.packed_byte = acc_q[7:0];
		out_data.overflowed  = ovf_q;
		// in emit, the byte is last only if no more bytes nor tokens follow
		out_data.run_last    = (state_q == ST_FLUSH) || ((state_q == ST_EMIT) && emit_last);
		out_data.stream_end  = (state_q == ST_FLUSH)
			|| ((state_q == ST_EMIT) && emit_last && end_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rcvd_q    <= '0;
			pos_q     <= '0;
			ctx_q     <= '0;
			acc_q     <= '0;
			nbits_q   <= '0;
			ovf_q     <= 1'b0;
			end_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 9'd1;
				ST_IDLE: if (xfer_in) begin
					end_q <= in_data.end_of_input;
					if (rcvd_q < CW'(HistoryBytes)) rcvd_q <= rcvd_q + CW'(1);
					else ovf_q <= 1'b1;
				end
				ST_CHECK: clr_q <= '0;
				ST_TOKEN: begin
					acc_q   <= acc_q | (16'(word) << nbits_q);
					nbits_q <= nbits_q + 5'd9;
					pos_q   <= pos_q + CW'(tok_len);
				end
				ST_CTX_WAIT: ctx_q <= (last_pos < CW'(HistoryBytes)) ? h_rdata : 8'd0;
				ST_EMIT: if (xfer_out) begin
					acc_q   <= acc_q >> 8;
					nbits_q <= nbits_q - 5'd8;
				end
				ST_FLUSH: if (end_q && (nbits_q == 5'd0 || xfer_out)) begin
					rcvd_q <= '0; pos_q <= '0; ctx_q <= '0; ovf_q <= 1'b0;
					acc_q <= '0; nbits_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// search datapath: one byte compare per pass
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CNT_RD: begin
				slot_q      <= '0;
				best_len_q  <= '0;
				best_slot_q <= '0;
				cnt_q       <= c_rdata;
				limit_q     <= (avail < CW'(MaxMatch)) ? 4'(avail) : 4'(MaxMatch);
			end
			ST_SLOT_WAIT: begin
				src_q  <= s_rdata;
				len_q  <= '0;
				miss_q <= 1'b0;
			end
			ST_CMP_RD: if (slot_done) begin
				if (len_q > best_len_q) begin
					best_len_q  <= len_q;
					best_slot_q <= slot_q[4:0];
				end
				slot_q <= slot_q + 6'd1;
			end
			ST_CMP_WAIT: a_byte_q <= h_rdata;
			ST_CMP: begin
				if (a_byte_q == h_rdata) len_q <= len_q + 4'd1;
				else miss_q <= 1'b1;
			end
			default: ;
		endcase
		if (state_q == ST_CNT_RD) cur_q <= h_rdata;
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("output offered while taking input");
	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= rcvd_q)
		else $error("encoder passed received data");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOKEN) |=> nbits_q <= 5'd16)
		else $error("bit accumulator overrun");
endmodule

>>> sv/lzss_ram.sv
module lzss_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
